@@ rtl/core/glucose_rise_detector_core_assert.svh @@
// Assertion macros for the glucose rise detector core.
// Needs nothing else; taken in by the top level with an include.
`ifndef GLUCOSE_RISE_DETECTOR_CORE_ASSERT_SVH
`define GLUCOSE_RISE_DETECTOR_CORE_ASSERT_SVH

// Same-cycle implication, skipped while reset is high
`define GRD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("glucose rise detector: assertion failed");

// Next-cycle implication, skipped while reset is high
`define GRD_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("glucose rise detector: assertion failed");

`endif

@@ rtl/core/grd_pkg.sv @@
// Package of the glucose rise detector: beat types, control structs, constants.
// Depends on nothing; used by every module of the core.
package grd_pkg;

   localparam int TIME_W      = 32;
   localparam int GLU_W       = 10;
   localparam int CSR_W       = 10;
   localparam int RATE_SCALE  = 3600;
   localparam int RATE_A      = 95;
   localparam int RATE_B      = 90;
   localparam int SEC_PER_MIN = 60;
   localparam int MAX_RESULTS = 4;
   localparam int HIST_DEPTH  = 3;
   localparam int CNT_W       = 3;
   localparam int GAP_SEC_W   = 16;

   localparam logic [CSR_W-1:0] GAP_MINUTES_RST       = 10'd15;
   localparam logic [CSR_W-1:0] GLUCOSE_THRESHOLD_RST = 10'd130;

   typedef enum logic [0:0] {
      CSR_GAP_MINUTES       = 1'b0,
      CSR_GLUCOSE_THRESHOLD = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [TIME_W-1:0] sample_time;
      logic [GLU_W-1:0]  glucose;
      logic              sample_valid;
      logic              series_end;
   } req_type;

   typedef struct packed {
      logic rise_flag;
      logic rise_onset;
      logic last_of_run;
   } rsp_type;

   // Results caused by one sample, entry 0 goes out first
   typedef struct packed {
      rsp_type [MAX_RESULTS-1:0] entries;
      logic [CNT_W-1:0]          count;
   } grd_grp_type;

   // Result queue status towards the input stage
   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic             can_load;
   } grd_q_stat_type;

endpackage

@@ rtl/core/glucose_rise_detector_core.sv @@
// Top level of the glucose rise detector: input register, settings, evaluation
// and result queue. Uses grd_pkg, grd_eval, grd_out_queue and the assert header.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_data  (grd_pkg::req_type)
//   rsp      out        rsp_valid / rsp_ready  rsp_data  (grd_pkg::rsp_type)
//   csr      in         csr_wr_en              csr_index, csr_wdata
//
// One sample a cycle is taken while req_ready is high; a sample waits in the
// input register until the queue can take its group. A series end gives up
// to four results, sent one beat a cycle while rsp_ready is high; the queue
// takes the next group when it has at most one beat left and that beat goes.
// Reset is synchronous, clears all series state and resets the settings to defaults.
// A stalled rsp side fills the input register, then drops req_ready.
`include "glucose_rise_detector_core_assert.svh"

module glucose_rise_detector_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  grd_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output grd_pkg::rsp_type          rsp_data,
   input  logic                      csr_wr_en,
   input  grd_pkg::csr_index_type    csr_index,
   input  logic [grd_pkg::CSR_W-1:0] csr_wdata
);
   import grd_pkg::*;

   logic              in_valid_ff, in_valid_in;
   req_type           in_data_ff;
   logic [CSR_W-1:0]  gap_ff, threshold_ff;
   logic              advance;
   grd_grp_type       group;
   grd_q_stat_type    q_stat;

   // settings
   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff       <= GAP_MINUTES_RST;
         threshold_ff <= GLUCOSE_THRESHOLD_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_GAP_MINUTES:       gap_ff       <= csr_wdata;
            CSR_GLUCOSE_THRESHOLD: threshold_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register, moves on when the queue can take its group
   always_comb begin
      advance     = in_valid_ff & q_stat.can_load;
      req_ready   = ~in_valid_ff | advance;
      in_valid_in = (req_valid & req_ready) | (in_valid_ff & ~advance);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
   end

   grd_eval u_eval (
      .clock             (clock),
      .reset             (reset),
      .in_data           (in_data_ff),
      .advance           (advance),
      .gap_minutes       (gap_ff),
      .glucose_threshold (threshold_ff),
      .group             (group)
   );

   grd_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .group     (group),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .stat      (q_stat)
   );

   // checks
   `GRD_ASSERT_IMP(a_queue_depth, clock, reset, 1'b1, q_stat.count <= CNT_W'(MAX_RESULTS))
   `GRD_ASSERT_IMP(a_onset, clock, reset, rsp_valid && rsp_data.rise_onset, rsp_data.rise_flag)
   `GRD_ASSERT_NXT(a_stall_hold, clock, reset, in_valid_ff && !advance, in_valid_ff)
   `GRD_ASSERT_NXT(a_stall_data, clock, reset, in_valid_ff && !advance, $stable(in_data_ff))

endmodule

@@ rtl/core/grd_rate_cmp.sv @@
// Division-free rate test: is (g_new-g_old)/(t_new-t_old) in mg/dL per hour
// at least 95 (sel_b low) or 90 (sel_b high). Uses grd_pkg.
module grd_rate_cmp (
   input  logic [grd_pkg::GLU_W-1:0]  g_new,
   input  logic [grd_pkg::GLU_W-1:0]  g_old,
   input  logic [grd_pkg::TIME_W-1:0] t_new,
   input  logic [grd_pkg::TIME_W-1:0] t_old,
   input  logic                       sel_b,
   output logic                       hit
);
   import grd_pkg::*;

   logic signed [GLU_W:0]  dg;
   logic signed [TIME_W:0] dt;
   logic signed [41:0]     lhs;
   logic signed [41:0]     rhs;

   // differences, then both sides scaled by constants
   always_comb begin
      dg  = $signed({1'b0, g_new}) - $signed({1'b0, g_old});
      dt  = $signed({1'b0, t_new}) - $signed({1'b0, t_old});
      lhs = 42'(dg) * 42'sd3600;
      if (sel_b) begin
         rhs = 42'(dt) * 42'sd90;
      end else begin
         rhs = 42'(dt) * 42'sd95;
      end
      if (dt > 0) begin
         hit = (lhs >= rhs);
      end else if (dt < 0) begin
         hit = (lhs <= rhs);
      end else begin
         hit = (dg > 0);
      end
   end

endmodule

@@ rtl/core/grd_eval.sv @@
// Per-sample evaluation: sample history, trigger rules, marking windows and
// the group of results each sample causes. Uses grd_pkg and grd_rate_cmp.
module grd_eval (
   input  logic                      clock,
   input  logic                      reset,
   input  grd_pkg::req_type          in_data,
   input  logic                      advance,
   input  logic [grd_pkg::CSR_W-1:0] gap_minutes,
   input  logic [grd_pkg::CSR_W-1:0] glucose_threshold,
   output grd_pkg::grd_grp_type      group
);
   import grd_pkg::*;

   logic [GLU_W-1:0]  past_glucose_ff [HIST_DEPTH];
   logic [TIME_W-1:0] past_time_ff    [HIST_DEPTH];
   logic [HIST_DEPTH-1:0] past_valid_ff, past_valid_in;
   logic [1:0]        seen_ff, seen_in;
   logic [TIME_W-1:0] start_a_ff, start_a_in, start_b_ff, start_b_in;
   logic              open_a_ff, open_a_in, open_b_ff, open_b_in;
   logic              pending_ff, pending_in;
   logic              prev_flag_ff, prev_flag_in;

   logic a1, a2, b1, b2, b3;
   logic full, all_valid, trig_a, trig_b;
   logic [TIME_W-1:0] start_a_eff, start_b_eff;
   logic              open_a_eff, open_b_eff;
   logic signed [TIME_W:0] d_a, d_b;
   logic [GAP_SEC_W-1:0]   gap_sec;
   logic amark, bmark, f0;
   logic shift, clear;

   // five rate tests in parallel
   grd_rate_cmp u_a1 (.g_new(in_data.glucose), .g_old(past_glucose_ff[0]),
      .t_new(in_data.sample_time), .t_old(past_time_ff[0]), .sel_b(1'b0), .hit(a1));
   grd_rate_cmp u_a2 (.g_new(past_glucose_ff[0]), .g_old(past_glucose_ff[1]),
      .t_new(past_time_ff[0]), .t_old(past_time_ff[1]), .sel_b(1'b0), .hit(a2));
   grd_rate_cmp u_b1 (.g_new(in_data.glucose), .g_old(past_glucose_ff[0]),
      .t_new(in_data.sample_time), .t_old(past_time_ff[0]), .sel_b(1'b1), .hit(b1));
   grd_rate_cmp u_b2 (.g_new(past_glucose_ff[0]), .g_old(past_glucose_ff[1]),
      .t_new(past_time_ff[0]), .t_old(past_time_ff[1]), .sel_b(1'b1), .hit(b2));
   grd_rate_cmp u_b3 (.g_new(past_glucose_ff[1]), .g_old(past_glucose_ff[2]),
      .t_new(past_time_ff[1]), .t_old(past_time_ff[2]), .sel_b(1'b1), .hit(b3));

   // triggers and windows
   always_comb begin
      full      = (seen_ff == 2'd3);
      all_valid = in_data.sample_valid & (&past_valid_ff);
      trig_a    = full & all_valid & a1 & a2 & (glucose_threshold <= past_glucose_ff[1]);
      trig_b    = full & all_valid & ~trig_a & b3 & (b2 | b1)
                  & (glucose_threshold <= past_glucose_ff[2]);
      start_a_eff = trig_a ? in_data.sample_time : start_a_ff;
      open_a_eff  = trig_a | open_a_ff;
      start_b_eff = trig_b ? in_data.sample_time : start_b_ff;
      open_b_eff  = trig_b | open_b_ff;
      gap_sec = GAP_SEC_W'(gap_minutes * SEC_PER_MIN);
      d_a = $signed({1'b0, in_data.sample_time}) - $signed({1'b0, start_a_eff});
      d_b = $signed({1'b0, in_data.sample_time}) - $signed({1'b0, start_b_eff});
      amark = open_a_eff & (d_a <= $signed({{(TIME_W+1-GAP_SEC_W){1'b0}}, gap_sec}));
      bmark = open_b_eff & (d_b <= $signed({{(TIME_W+1-GAP_SEC_W){1'b0}}, gap_sec}));
      f0 = pending_ff | bmark;
   end

   // result group and next state
   always_comb begin
      group        = '0;
      shift        = ~in_data.series_end;
      clear        = in_data.series_end;
      seen_in      = seen_ff;
      start_a_in   = start_a_ff;
      start_b_in   = start_b_ff;
      open_a_in    = open_a_ff;
      open_b_in    = open_b_ff;
      pending_in   = pending_ff;
      prev_flag_in = prev_flag_ff;
      if (full) begin
         if (in_data.series_end) begin
            group.count = CNT_W'(MAX_RESULTS);
            group.entries[0].rise_flag  = f0;
            group.entries[0].rise_onset = f0 & ~prev_flag_ff;
            group.entries[1].rise_flag  = amark;
            group.entries[1].rise_onset = amark & ~f0;
            group.entries[MAX_RESULTS-1].last_of_run = 1'b1;
         end else begin
            group.count = CNT_W'(1);
            group.entries[0].rise_flag  = f0;
            group.entries[0].rise_onset = f0 & ~prev_flag_ff;
            start_a_in   = start_a_eff;
            start_b_in   = start_b_eff;
            open_a_in    = amark;
            open_b_in    = bmark;
            pending_in   = amark;
            prev_flag_in = f0;
         end
      end else if (in_data.series_end) begin
         // short series: all zero, last mark after the stored samples
         group.count = CNT_W'(seen_ff) + CNT_W'(1);
         for (int i = 0; i < MAX_RESULTS; i++) begin
            group.entries[i].last_of_run = (CNT_W'(i) == CNT_W'(seen_ff));
         end
      end else begin
         seen_in = seen_ff + 2'd1;
      end
   end

   always_comb begin
      past_valid_in = {past_valid_ff[HIST_DEPTH-2:0], in_data.sample_valid};
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset || (advance && clear)) begin
         past_valid_ff <= '0;
         seen_ff       <= '0;
         start_a_ff    <= '0;
         start_b_ff    <= '0;
         open_a_ff     <= 1'b0;
         open_b_ff     <= 1'b0;
         pending_ff    <= 1'b0;
         prev_flag_ff  <= 1'b0;
      end else if (advance) begin
         if (shift) begin
            past_valid_ff <= past_valid_in;
         end
         seen_ff      <= seen_in;
         start_a_ff   <= start_a_in;
         start_b_ff   <= start_b_in;
         open_a_ff    <= open_a_in;
         open_b_ff    <= open_b_in;
         pending_ff   <= pending_in;
         prev_flag_ff <= prev_flag_in;
      end
   end

   // history of glucose and time
   always_ff @(posedge clock) begin
      if (reset || (advance && clear)) begin
         for (int i = 0; i < HIST_DEPTH; i++) begin
            past_glucose_ff[i] <= '0;
            past_time_ff[i]    <= '0;
         end
      end else if (advance && shift) begin
         for (int i = HIST_DEPTH-1; i > 0; i--) begin
            past_glucose_ff[i] <= past_glucose_ff[i-1];
            past_time_ff[i]    <= past_time_ff[i-1];
         end
         past_glucose_ff[0] <= in_data.glucose;
         past_time_ff[0]    <= in_data.sample_time;
      end
   end

endmodule

@@ rtl/core/grd_out_queue.sv @@
// Result queue: holds the group of one sample and sends it out one beat a
// cycle while rsp_ready is high, oldest first. Uses grd_pkg.
module grd_out_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  grd_pkg::grd_grp_type   group,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output grd_pkg::rsp_type       rsp_data,
   output grd_pkg::grd_q_stat_type stat
);
   import grd_pkg::*;

   rsp_type [MAX_RESULTS-1:0] entries_ff, entries_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic                      pop;

   // pop a beat, or replace the contents with a new group
   always_comb begin
      pop        = rsp_valid & rsp_ready;
      entries_in = entries_ff;
      count_in   = count_ff;
      if (load) begin
         entries_in = group.entries;
         count_in   = group.count;
      end else if (pop) begin
         for (int i = 0; i < MAX_RESULTS-1; i++) begin
            entries_in[i] = entries_ff[i+1];
         end
         entries_in[MAX_RESULTS-1] = '0;
         count_in = count_ff - CNT_W'(1);
      end
      stat.count    = count_ff;
      stat.can_load = (count_ff == '0) || ((count_ff == CNT_W'(1)) && rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      entries_ff <= entries_in;
   end

   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = entries_ff[0];

endmodule
